[src/sdw_pkg.sv]
// Shared constants for the stereo delay widener.
`timescale 1ns / 1ps
package sdw_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int DELAY_W       = 16;
    localparam int WEIGHT_W      = 17;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 17;
    localparam int BUF_DEPTH_DEF = 65536;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd32768;
    localparam logic [DELAY_W-1:0]  DELAY_RESET  = 16'd1;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 1'b1;

endpackage

[src/sdw_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module sdw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/sdw_addr_gen.sv]
// Write pointer, read address and first-pass fill tracking for the delay store.
`timescale 1ns / 1ps
module sdw_addr_gen
    import sdw_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  logic [DELAY_W-1:0]           delay_samples,
    output logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
    output logic [$clog2(BUF_DEPTH)-1:0] rd_addr,
    output logic                         rd_written
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int EW = (AW + 1 > DELAY_W + 1) ? AW + 1 : DELAY_W + 1;

    logic [AW-1:0] wp_reg, wp_next;
    logic          wrapped_reg, wrapped_next;
    logic [EW-1:0] d_ext;
    logic [AW-1:0] d_eff;
    logic [AW:0]   rd_wide;

    always_comb begin
        d_ext = EW'(delay_samples);
        if (delay_samples == '0) begin
            d_ext = EW'(1);
        end
        if (d_ext >= EW'(BUF_DEPTH)) begin
            d_ext = EW'(BUF_DEPTH - 1);
        end
        d_eff = d_ext[AW-1:0];

        if (wp_reg >= d_eff) begin
            rd_wide = {1'b0, wp_reg} - {1'b0, d_eff};
        end else begin
            rd_wide = {1'b0, wp_reg} + (AW+1)'(BUF_DEPTH) - {1'b0, d_eff};
        end
    end

    assign rd_addr    = rd_wide[AW-1:0];
    assign wr_addr    = wp_reg;
    // before the first wrap only entries below the write pointer hold data
    assign rd_written = wrapped_reg || (rd_addr < wp_reg);

    always_comb begin
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        if (advance) begin
            if (wp_reg == AW'(BUF_DEPTH - 1)) begin
                wp_next      = '0;
                wrapped_next = 1'b1;
            end else begin
                wp_next = wp_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end else begin
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_next;
        end
    end

endmodule

[src/sdw_mix.sv]
// Weighted left/right mix: product stage, then sum, round and output register.
`timescale 1ns / 1ps
module sdw_mix
    import sdw_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] dry,
    input  logic signed [SAMPLE_W-1:0] delayed,
    input  logic [WEIGHT_W-1:0]        weight,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [2*SAMPLE_W-1:0]      m_tdata    // [15:0] left_out, [31:16] right_out
);

    localparam int PW = SAMPLE_W + WEIGHT_W + 1;

    logic [WEIGHT_W-1:0]  wd, wn;
    logic signed [PW-1:0] p_del_wd_reg, p_del_wn_reg, p_dry_wd_reg, p_dry_wn_reg;
    logic                 p_valid_reg;
    logic                 p_ready;
    logic signed [PW:0]   sum_l, sum_r;
    logic [SAMPLE_W-1:0]  left_reg, right_reg;
    logic                 out_valid_reg;

    assign wd = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
    assign wn = WEIGHT_ONE - wd;

    assign p_ready  = !out_valid_reg || m_tready;
    assign in_ready = !p_valid_reg || p_ready;

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            p_del_wd_reg <= delayed * $signed({1'b0, wd});
            p_del_wn_reg <= delayed * $signed({1'b0, wn});
            p_dry_wd_reg <= dry * $signed({1'b0, wd});
            p_dry_wn_reg <= dry * $signed({1'b0, wn});
        end
    end

    // nearest, ties toward plus infinity
    assign sum_l = (PW+1)'(p_del_wd_reg) + (PW+1)'(p_dry_wn_reg) + (PW+1)'(32768);
    assign sum_r = (PW+1)'(p_del_wn_reg) + (PW+1)'(p_dry_wd_reg) + (PW+1)'(32768);

    always_ff @(posedge aclk) begin
        if (p_valid_reg && p_ready) begin
            left_reg  <= sum_l[SAMPLE_W+15:16];
            right_reg <= sum_r[SAMPLE_W+15:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                p_valid_reg <= in_valid;
            end
            if (p_ready) begin
                out_valid_reg <= p_valid_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {right_reg, left_reg};

endmodule

[src/stereo_delay_widener.sv]
// Top level of the stereo delay widener.
`timescale 1ns / 1ps
// Takes one mono Q1.15 sample per transfer and returns one left/right pair per
// transfer, one item per clock when both sides keep up. An input transfer
// reaches output valid through the delay store read, then the weight products,
// then sum and rounding into the output register.
// The delay store is a single RAM of BUF_DEPTH samples with registered read data;
// each item reads its delayed sample and writes itself in the same cycle, on
// separate ports. Entries never written since reset read as zero through
// fill tracking on the write pointer, so there is no clearing pass and the
// block accepts input straight out of reset. delay_samples (index 0) is
// clamped to 1..BUF_DEPTH-1, delayed_weight (index 1) to at most 65536;
// write them only while idle.
module stereo_delay_widener
    import sdw_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,    // [15:0] sample_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*SAMPLE_W-1:0] m_tdata,    // [15:0] left_out, [31:16] right_out
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(BUF_DEPTH);

    logic [DELAY_W-1:0]  delay_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    logic                s_xfer;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic                rd_written;
    logic [SAMPLE_W-1:0] ram_rdata;

    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_dry_reg;
    logic                s1_written_reg;
    logic                s1_ready;
    logic [SAMPLE_W-1:0] s1_delayed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg  <= DELAY_RESET;
            weight_reg <= WEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DELAY:  delay_reg  <= cfg_wdata[DELAY_W-1:0];
                REG_WEIGHT: weight_reg <= cfg_wdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !s1_valid_reg || s1_ready;
    assign s_xfer   = s_tvalid && s_tready;

    sdw_addr_gen #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_addr (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (s_xfer),
        .delay_samples (delay_reg),
        .wr_addr       (wr_addr),
        .rd_addr       (rd_addr),
        .rd_written    (rd_written)
    );

    sdw_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(BUF_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (s_xfer),
        .waddr (wr_addr),
        .wdata (s_tdata),
        .re    (s_xfer),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_dry_reg     <= s_tdata;
            s1_written_reg <= rd_written;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    assign s1_delayed = s1_written_reg ? ram_rdata : '0;

    sdw_mix u_mix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s1_valid_reg),
        .in_ready (s1_ready),
        .dry      ($signed(s1_dry_reg)),
        .delayed  ($signed(s1_delayed)),
        .weight   (weight_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_no_self_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |-> rd_addr != wr_addr)
        else $error("delay store read and write collide");

    a_stage_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> s1_valid_reg)
        else $error("accepted sample not held in read stage");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_ready |=> s1_valid_reg && $stable(s1_dry_reg))
        else $error("stalled read stage lost its sample");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_tready)
        else $error("input stalled with empty read stage");

endmodule

[tb/tb_stereo_delay_widener.sv]
// Self-checking testbench for the stereo delay widener: stream stimulus, predictor, scoreboard.
`timescale 1ns / 1ps
module tb_stereo_delay_widener;
    import sdw_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int DEPTH       = BUF_DEPTH_DEF;
    localparam int IDLE_PCT    = 13;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG    = 3000;
    localparam int PHASE_ITEMS = 250;

    typedef struct packed {
        logic [SAMPLE_W-1:0] right;
        logic [SAMPLE_W-1:0] left;
    } lr_pair_t;

    class widener_scoreboard;
        logic [SAMPLE_W-1:0] history [DEPTH];
        int                  wr_pos;
        logic [DELAY_W-1:0]  delay_reg;
        logic [WEIGHT_W-1:0] weight_reg;
        lr_pair_t            pending_pairs [$];
        int                  errors;
        int                  samples_seen;
        int                  pairs_checked;

        function new();
            foreach (history[i]) history[i] = '0;
            wr_pos     = 0;
            delay_reg  = DELAY_RESET;
            weight_reg = WEIGHT_RESET;
            errors     = 0;
            samples_seen  = 0;
            pairs_checked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_DELAY)
                delay_reg = val[DELAY_W-1:0];
            else if (idx == REG_WEIGHT)
                weight_reg = val[WEIGHT_W-1:0];
        endfunction

        // Rounds a Q2.31 sum to Q1.15, nearest, ties up.
        function logic [SAMPLE_W-1:0] round_q15(longint acc);
            longint r;
            r = (acc + 64'sd32768) >>> 16;
            return r[SAMPLE_W-1:0];
        endfunction

        function void take_sample(logic [SAMPLE_W-1:0] x);
            longint   d;
            longint   w;
            longint   dry;
            longint   dly;
            int       rd;
            lr_pair_t p;
            d = delay_reg;
            if (d < 1) d = 1;
            if (d >= DEPTH) d = DEPTH - 1;
            w = weight_reg;
            if (w > longint'(WEIGHT_ONE)) w = WEIGHT_ONE;
            rd  = (wr_pos + DEPTH - int'(d)) % DEPTH;
            dry = longint'($signed(x));
            dly = longint'($signed(history[rd]));
            history[wr_pos] = x;
            wr_pos = (wr_pos + 1) % DEPTH;
            p.left  = round_q15(dly * w + dry * (65536 - w));
            p.right = round_q15(dly * (65536 - w) + dry * w);
            pending_pairs.push_back(p);
            samples_seen++;
        endfunction

        function void compare_pair(logic [2*SAMPLE_W-1:0] data);
            lr_pair_t got;
            lr_pair_t exp_p;
            got = data;
            if (pending_pairs.size() == 0) begin
                $error("unexpected result transfer: left_out %0d right_out %0d",
                       $signed(got.left), $signed(got.right));
                errors++;
                return;
            end
            exp_p = pending_pairs.pop_front();
            pairs_checked++;
            if (got.left !== exp_p.left) begin
                $error("left_out mismatch: expected %0d, actual %0d",
                       $signed(exp_p.left), $signed(got.left));
                errors++;
            end
            if (got.right !== exp_p.right) begin
                $error("right_out mismatch: expected %0d, actual %0d",
                       $signed(exp_p.right), $signed(got.right));
                errors++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [2*SAMPLE_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    widener_scoreboard sb = new();

    bit steady       = 1'b0;
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int stall_cycles = 0;
    int settings_run = 1;

    stereo_delay_widener DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.compare_pair(m_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] x);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_sample(x);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_pairs.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge aclk);
        sb.set_reg(idx, val[CFG_DATA_W-1:0]);
    endtask

    task automatic configure(input int dly, input int wgt);
        drain();
        write_reg(REG_DELAY, dly);
        write_reg(REG_WEIGHT, wgt);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    logic [SAMPLE_W-1:0] corner_samples [12] = '{
        16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555,
        16'hAAAA, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8001
    };
    int phase_delay  [8] = '{1, 65535, 3, 0, 1000, 255, 12, 0};
    int phase_weight [8] = '{0, 0, 65536, 131071, 0, 0, 49152, 0};

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: delay 1, weight one half; first reads come from never-written entries, which read as zero.
        foreach (corner_samples[i]) send_sample(corner_samples[i]);
        configure(0, 0);
        repeat (4) send_sample(pick_sample());
        configure(2, 65536);
        repeat (4) send_sample(pick_sample());
        configure(65535, 131071);
        repeat (4) send_sample(pick_sample());

        phase_weight[0] = $urandom_range(65536);
        phase_weight[4] = $urandom_range(131071);
        phase_weight[5] = $urandom_range(65536);
        phase_delay[7]  = $urandom_range(64);
        phase_weight[7] = $urandom_range(131071);
        for (int ph = 0; ph < 8; ph++) begin
            configure(phase_delay[ph], phase_weight[ph]);
            steady = (ph == 6);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == 20) hold_request = 1'b1;
                if (ph == 4 && n == 100) drain();
                send_sample(pick_sample());
            end
        end
        steady = 1'b0;

        drain();
        repeat (10) @(posedge aclk);
        $display("covered %0d input transfers and %0d checked result pairs over %0d settings",
                 sb.samples_seen, sb.pairs_checked, settings_run);
        $display("including clamped delay and weight, full-scale samples and a long output stall");
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
